/* hw/rtl/bsfbm_pkg.sv */
// ----------------------------------------------------------------------------
// bsfbm_pkg
// Shared types and fixed field counts of the batch resemblance matcher.
// ----------------------------------------------------------------------------
package bsfbm_pkg;

  localparam int FEAT   = 3;   // super-features per chunk
  localparam int HWORDS = 4;   // 64-bit words per chunk hash

  typedef logic [FEAT-1:0][63:0]   feat_vec_t;
  typedef logic [HWORDS-1:0][63:0] hash_t;

  typedef struct packed {
    feat_vec_t       feat;
    hash_t           hash;
    logic            eob;
    logic [FEAT-1:0] dup;   // feature repeats an earlier one of the same chunk
  } item_t;

  typedef struct packed {
    logic  similar;
    hash_t base;
  } res_t;

endpackage

/* hw/rtl/batch_super_feature_base_match_core.sv */
// ----------------------------------------------------------------------------
// batch_super_feature_base_match_core
// Batch-local super-feature resemblance detector with base hash selection.
// ----------------------------------------------------------------------------
// Each pushed word is one chunk: three super-features, a 256-bit hash and an
// end-of-batch flag. One result word comes out per chunk, in order. The
// feature index is a linearly scanned key RAM. A chunk is taken from the
// input queue and then scanned against the keys stored so far in the batch
// (one key RAM read a cycle, plus the last compare and the hand-over). Then
// a similar chunk goes through decide, a hash RAM fetch and load for each
// feature, compare and result; an inserted one through decide, hash write,
// a key write for each feature that does not repeat an earlier one while the
// index has room, and result; and one that finds the hash slots used up
// through decide and result. The result step waits while an earlier result
// word is still held. The index clears by resetting its fill counts, so
// there is no clearing pass and no dead time after reset or at end of batch.
// A two-word input queue keeps taking chunks while the engine works, and a
// result register lets the next chunk run while a result waits to be popped.
// ----------------------------------------------------------------------------
module batch_super_feature_base_match_core #(
  parameter int BATCH_CHUNKS  = 128,
  parameter int INDEX_ENTRIES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_feature_0,
  input  logic [63:0] in_feature_1,
  input  logic [63:0] in_feature_2,
  input  logic [63:0] in_hash_word_0,
  input  logic [63:0] in_hash_word_1,
  input  logic [63:0] in_hash_word_2,
  input  logic [63:0] in_hash_word_3,
  input  logic        in_end_of_batch,
  output logic        empty,
  input  logic        pop,
  output logic        out_batch_similar,
  output logic [63:0] out_base_word_0,
  output logic [63:0] out_base_word_1,
  output logic [63:0] out_base_word_2,
  output logic [63:0] out_base_word_3
);
  import bsfbm_pkg::*;

  feat_vec_t feat;
  hash_t     hash;
  logic      q_vld, q_pop, out_vld;
  item_t     q_item;
  res_t      res;

  // pack the chunk word
  assign feat = {in_feature_2, in_feature_1, in_feature_0};
  assign hash = {in_hash_word_3, in_hash_word_2, in_hash_word_1, in_hash_word_0};

  // front: classify repeats and queue chunks
  bsfbm_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .feat(feat), .hash(hash), .eob(in_end_of_batch),
    .q_vld(q_vld), .q_item(q_item), .q_pop(q_pop)
  );

  // back: look up, tally or insert, and hold the result word
  bsfbm_back #(.BATCH_CHUNKS(BATCH_CHUNKS), .INDEX_ENTRIES(INDEX_ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_vld(q_vld), .q_item(q_item), .q_pop(q_pop),
    .out_vld(out_vld), .out_res(res), .out_pop(pop)
  );

  // unpack the result word
  assign empty             = !out_vld;
  assign out_batch_similar = res.similar;
  assign out_base_word_0   = res.base[0];
  assign out_base_word_1   = res.base[1];
  assign out_base_word_2   = res.base[2];
  assign out_base_word_3   = res.base[3];

endmodule

/* hw/rtl/bsfbm_ram.sv */
// ----------------------------------------------------------------------------
// bsfbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsfbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bsfbm_front.sv */
// ----------------------------------------------------------------------------
// bsfbm_front
// Accept chunk words, mark repeated features, and hold them in a two-entry
// queue for the match engine.
// ----------------------------------------------------------------------------
module bsfbm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  bsfbm_pkg::feat_vec_t feat,
  input  bsfbm_pkg::hash_t     hash,
  input  logic                eob,
  output logic                q_vld,
  output bsfbm_pkg::item_t     q_item,
  input  logic                q_pop
);
  import bsfbm_pkg::*;

  item_t       ent_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wr, rd;
  item_t       in_item;

  always_comb begin
    in_item.feat = feat;
    in_item.hash = hash;
    in_item.eob  = eob;
    for (int i = 0; i < FEAT; i++) begin
      in_item.dup[i] = 1'b0;
      for (int j = 0; j < i; j++) begin
        if (feat[j] == feat[i]) in_item.dup[i] = 1'b1;
      end
    end
  end

  assign full   = (cnt_r == 2'd2);
  assign q_vld  = (cnt_r != 2'd0);
  assign q_item = ent_r[rp_r];
  assign wr     = push && !full;
  assign rd     = q_pop && q_vld;

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) ent_r[wp_r] <= in_item;
  end

endmodule

/* hw/rtl/bsfbm_back.sv */
// ----------------------------------------------------------------------------
// bsfbm_back
// Match engine: scan the key index, tally matched hashes or, while hash slots
// remain, insert the chunk, and hold one result word for the output side.
// ----------------------------------------------------------------------------
module bsfbm_back #(
  parameter int BATCH_CHUNKS  = 128,
  parameter int INDEX_ENTRIES = 512
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_vld,
  input  bsfbm_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_vld,
  output bsfbm_pkg::res_t  out_res,
  input  logic            out_pop
);
  import bsfbm_pkg::*;

  localparam int KAW = $clog2(INDEX_ENTRIES);
  localparam int KCW = $clog2(INDEX_ENTRIES + 1);
  localparam int SW  = (BATCH_CHUNKS > 1) ? $clog2(BATCH_CHUNKS) : 1;
  localparam int SCW = $clog2(BATCH_CHUNKS + 1);
  localparam int FIW = (FEAT > 1) ? $clog2(FEAT) : 1;
  localparam int TW  = $clog2(FEAT + 1);
  localparam logic [FIW-1:0] FI_LAST = FIW'(FEAT - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_LOAD   = 4'd4;
  localparam logic [3:0] S_CMP    = 4'd5;
  localparam logic [3:0] S_INS_H  = 4'd6;
  localparam logic [3:0] S_INS_K  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]     state_r, state_nxt;
  item_t          item_r, item_nxt;
  logic [KCW-1:0] key_cnt_r, key_cnt_nxt, scan_r, scan_nxt;
  logic [SCW-1:0] slot_cnt_r, slot_cnt_nxt;
  logic           rd_vld_r, rd_vld_nxt;
  logic [FEAT-1:0] hit_r, hit_nxt;
  logic [SW-1:0]  slot_r [FEAT];
  logic [SW-1:0]  slot_nxt [FEAT];
  logic [FIW-1:0] fi_r, fi_nxt;
  hash_t          hv_r [FEAT];
  logic [FEAT-1:0] eq_r [FEAT];
  logic [FEAT-1:0] eq_nxt [FEAT];
  logic           out_vld_r, out_vld_nxt;
  res_t           out_r, out_nxt;

  logic           k_we, k_re, h_we, h_re, hv_we;
  logic [KAW-1:0] k_waddr, k_raddr;
  logic [SW+63:0] k_wdata, k_rdata;
  logic [SW-1:0]  h_waddr, h_raddr;
  hash_t          h_rdata;

  logic [TW-1:0]  cnt [FEAT];
  logic [TW-1:0]  best;
  logic [FEAT-1:0] top, qual;
  logic [FIW-1:0] first_i, qual_i, base_i;
  res_t           res;

  bsfbm_ram #(.WIDTH(SW + 64), .DEPTH(INDEX_ENTRIES)) u_key_ram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .re(k_re), .raddr(k_raddr), .rdata(k_rdata)
  );

  bsfbm_ram #(.WIDTH(HWORDS * 64), .DEPTH(BATCH_CHUNKS)) u_hash_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(item_r.hash),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  // tally of matched hashes
  always_comb begin
    best    = '0;
    first_i = '0;
    qual_i  = '0;
    for (int i = FEAT - 1; i >= 0; i--) begin
      cnt[i] = hit_r[i] ? TW'($countones(eq_r[i] & hit_r)) : '0;
      if (hit_r[i]) first_i = FIW'(i);
    end
    for (int i = 0; i < FEAT; i++) begin
      if (cnt[i] > best) best = cnt[i];
    end
    for (int i = 0; i < FEAT; i++) begin
      top[i] = hit_r[i] && (cnt[i] == best);
    end
    for (int i = 0; i < FEAT; i++) begin
      qual[i] = top[i];
      for (int j = 0; j < i; j++) begin
        if (top[j] && eq_r[i][j]) qual[i] = 1'b0;
      end
    end
    for (int i = FEAT - 1; i >= 0; i--) begin
      if (qual[i]) qual_i = FIW'(i);
    end
    base_i = (best == TW'(1) || $countones(qual) > 1) ? first_i : qual_i;
    res.similar = |hit_r;
    res.base    = (|hit_r) ? hv_r[base_i] : '0;
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    key_cnt_nxt  = key_cnt_r;
    slot_cnt_nxt = slot_cnt_r;
    scan_nxt     = scan_r;
    rd_vld_nxt   = 1'b0;
    hit_nxt      = hit_r;
    slot_nxt     = slot_r;
    fi_nxt       = fi_r;
    eq_nxt       = eq_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_pop;
    q_pop        = 1'b0;
    k_we = 1'b0; k_re = 1'b0; h_we = 1'b0; h_re = 1'b0; hv_we = 1'b0;
    k_waddr = key_cnt_r[KAW-1:0];
    k_raddr = scan_r[KAW-1:0];
    k_wdata = {slot_cnt_r[SW-1:0], item_r.feat[fi_r]};
    h_waddr = slot_cnt_r[SW-1:0];
    h_raddr = slot_r[fi_r];

    unique case (state_r)
      S_IDLE: begin
        if (q_vld) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          hit_nxt   = '0;
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // one entry read a cycle; compare the previous entry's key
        if (rd_vld_r) begin
          for (int f = 0; f < FEAT; f++) begin
            if (!hit_r[f] && k_rdata[63:0] == item_r.feat[f]) begin
              hit_nxt[f]  = 1'b1;
              slot_nxt[f] = k_rdata[SW+63:64];
            end
          end
        end
        if (scan_r < key_cnt_r) begin
          k_re       = 1'b1;
          rd_vld_nxt = 1'b1;
          scan_nxt   = scan_r + KCW'(1);
        end else if (!rd_vld_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        fi_nxt = '0;
        if (|hit_r) state_nxt = S_FETCH;
        else if (slot_cnt_r < SCW'(BATCH_CHUNKS)) state_nxt = S_INS_H;
        else state_nxt = S_DONE;
      end
      S_FETCH: begin
        h_re      = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        hv_we = 1'b1;
        if (fi_r == FI_LAST) begin
          state_nxt = S_CMP;
        end else begin
          fi_nxt    = fi_r + FIW'(1);
          state_nxt = S_FETCH;
        end
      end
      S_CMP: begin
        for (int i = 0; i < FEAT; i++) begin
          for (int j = 0; j < FEAT; j++) begin
            eq_nxt[i][j] = (hv_r[i] == hv_r[j]);
          end
        end
        state_nxt = S_DONE;
      end
      S_INS_H: begin
        h_we      = 1'b1;
        fi_nxt    = '0;
        state_nxt = S_INS_K;
      end
      S_INS_K: begin
        if (!item_r.dup[fi_r] && key_cnt_r < KCW'(INDEX_ENTRIES)) begin
          k_we        = 1'b1;
          key_cnt_nxt = key_cnt_r + KCW'(1);
        end
        if (fi_r == FI_LAST) begin
          slot_cnt_nxt = slot_cnt_r + SCW'(1);
          state_nxt    = S_DONE;
        end else begin
          fi_nxt = fi_r + FIW'(1);
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_pop) begin
          out_nxt     = res;
          out_vld_nxt = 1'b1;
          if (item_r.eob) begin
            key_cnt_nxt  = '0;
            slot_cnt_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      key_cnt_r  <= '0;
      slot_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      key_cnt_r  <= key_cnt_nxt;
      slot_cnt_r <= slot_cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    scan_r <= scan_nxt;
    hit_r  <= hit_nxt;
    slot_r <= slot_nxt;
    fi_r   <= fi_nxt;
    eq_r   <= eq_nxt;
    out_r  <= out_nxt;
    if (hv_we) hv_r[fi_r] <= h_rdata;
  end

  assign out_vld = out_vld_r;
  assign out_res = out_r;

endmodule
